// File: rtl/core/obstacle_escape_motion_coordinator_unit_defines.svh
// Assertion helpers used by the top-level RTL file of the motion coordinator.
`ifndef OBSTACLE_ESCAPE_MOTION_COORDINATOR_UNIT_DEFINES_SVH
`define OBSTACLE_ESCAPE_MOTION_COORDINATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define OEMC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define OEMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/oemc_pkg.sv
package oemc_pkg;

   // Event opcodes.
   localparam logic [2:0] OP_SESSION   = 3'd0;
   localparam logic [2:0] OP_PROBE     = 3'd1;
   localparam logic [2:0] OP_DUST_REQ  = 3'd2;
   localparam logic [2:0] OP_DUST_DONE = 3'd3;
   localparam logic [2:0] OP_SNAPSHOT  = 3'd4;

   // Probe reasons; both "right turn" and "surrounded" suspend cleaning first.
   localparam logic [1:0] REASON_RIGHT_TURN = 2'd0;
   localparam logic [1:0] REASON_SURROUNDED = 2'd1;

   // Result kinds.
   localparam logic KIND_COMMAND = 1'b0;
   localparam logic KIND_ACTION  = 1'b1;

   // Motion commands.
   localparam logic [3:0] CMD_STOP          = 4'd0;
   localparam logic [3:0] CMD_SUPPRESS      = 4'd1;
   localparam logic [3:0] CMD_PROBE_RIGHT   = 4'd2;
   localparam logic [3:0] CMD_SPIN_CW       = 4'd3;
   localparam logic [3:0] CMD_SPIN_CCW      = 4'd4;
   localparam logic [3:0] CMD_SAFE_HOLD     = 4'd5;
   localparam logic [3:0] CMD_STOP_FALLBACK = 4'd6;
   localparam logic [3:0] CMD_HEADING       = 4'd7;
   localparam logic [3:0] CMD_REV_ESCAPE    = 4'd8;
   localparam logic [3:0] CMD_TURN_RIGHT    = 4'd9;
   localparam logic [3:0] CMD_TURN_LEFT     = 4'd10;
   localparam logic [3:0] CMD_FALLBACK      = 4'd11;
   localparam logic [3:0] CMD_FORWARD       = 4'd12;
   localparam logic [3:0] CMD_REVERSE       = 4'd13;

   // Cleaning actions.
   localparam logic [1:0] ACT_SUSPEND = 2'd0;
   localparam logic [1:0] ACT_BOOST   = 2'd1;
   localparam logic [1:0] ACT_NORMAL  = 2'd2;
   localparam logic [1:0] ACT_RESUME  = 2'd3;

   // Motion modes.
   localparam logic [2:0] MODE_STOPPED  = 3'd0;
   localparam logic [2:0] MODE_FWD      = 3'd1;
   localparam logic [2:0] MODE_BWD      = 3'd2;
   localparam logic [2:0] MODE_PROBING  = 3'd3;
   localparam logic [2:0] MODE_DUST     = 3'd4;
   localparam logic [2:0] MODE_AVOID    = 3'd5;
   localparam logic [2:0] MODE_SURR_REV = 3'd6;
   localparam logic [2:0] MODE_TURNING  = 3'd7;

   // Snapshot kinds that the rules name.
   localparam logic [4:0] SK_PARTIAL_STALE   = 5'd4;
   localparam logic [4:0] SK_AMBIGUOUS       = 5'd5;
   localparam logic [4:0] SK_VALID           = 5'd7;
   localparam logic [4:0] SK_UNSTABLE        = 5'd8;
   localparam logic [4:0] SK_RIGHT_VIABLE    = 5'd9;
   localparam logic [4:0] SK_LEFT_VIABLE     = 5'd10;
   localparam logic [4:0] SK_RIGHT_INVALID   = 5'd11;
   localparam logic [4:0] SK_NO_LATERAL      = 5'd12;
   localparam logic [4:0] SK_SURROUNDED      = 5'd13;
   localparam logic [4:0] SK_REVERSE_READ    = 5'd15;
   localparam logic [4:0] SK_REVERSE_SAMPLE  = 5'd16;
   localparam logic [4:0] SK_LATERAL_OPENING = 5'd17;
   localparam logic [4:0] SK_LEAD_BLOCKED    = 5'd18;
   localparam logic [4:0] SK_NOT_SURROUNDED  = 5'd19;
   localparam logic [4:0] SK_LEAD_SAFE       = 5'd20;

   localparam int MAX_RESULTS = 3;
   localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

   typedef struct packed {
      logic [2:0] opcode;
      logic       session_on;
      logic       set_direction;
      logic       direction_backward;
      logic [1:0] probe_reason;
      logic       snapshot_valid;
      logic [4:0] snapshot_kind;
      logic       front_blocked;
      logic       front_safe;
      logic       boxed_in;
      logic       right_open;
      logic       left_open;
   } req_payload_type;

   typedef struct packed {
      logic       result_kind;
      logic [3:0] motion_command;
      logic       probe_side;
      logic [1:0] cleaning_action;
      logic [2:0] motion_mode;
      logic       last_result;
   } rsp_payload_type;

   typedef struct packed {
      logic       session;
      logic       backward;
      logic [2:0] mode;
   } coord_state_type;

   typedef struct packed {
      logic [COUNT_W-1:0]                     count;
      rsp_payload_type [MAX_RESULTS-1:0]      results;
      coord_state_type                        next_state;
   } decision_type;

   function automatic rsp_payload_type make_cmd(input logic [3:0] code, input logic side);
      rsp_payload_type r;
      r                 = '0;
      r.result_kind     = KIND_COMMAND;
      r.motion_command  = code;
      r.probe_side      = side;
      return r;
   endfunction

   function automatic rsp_payload_type make_act(input logic [1:0] code);
      rsp_payload_type r;
      r                 = '0;
      r.result_kind     = KIND_ACTION;
      r.cleaning_action = code;
      return r;
   endfunction

endpackage

// File: rtl/core/oemc_stream_if.sv
interface oemc_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/oemc_decoder.sv
module oemc_decoder (
   input  oemc_pkg::req_payload_type req,
   input  oemc_pkg::coord_state_type state,
   output oemc_pkg::decision_type    decision
);

   oemc_pkg::coord_state_type                           nst;
   oemc_pkg::rsp_payload_type [oemc_pkg::MAX_RESULTS-1:0] res;
   logic [oemc_pkg::COUNT_W-1:0]                        n;
   logic [4:0]                                          kind;
   logic                                                back_next;
   logic                                                lead_rule;
   logic                                                surr_rule;
   logic [3:0]                                          lead_turn;

   assign kind = req.snapshot_kind;

   // Turn chosen after restoring heading when the leading sector is blocked.
   always_comb begin
      if (kind == oemc_pkg::SK_RIGHT_INVALID && req.left_open) begin
         lead_turn = oemc_pkg::CMD_TURN_LEFT;
      end else if (req.right_open) begin
         lead_turn = oemc_pkg::CMD_TURN_RIGHT;
      end else if (req.left_open) begin
         lead_turn = oemc_pkg::CMD_TURN_LEFT;
      end else begin
         lead_turn = oemc_pkg::CMD_FALLBACK;
      end
   end

   assign back_next = req.set_direction ? req.direction_backward : state.backward;

   assign surr_rule = req.boxed_in
                   || (kind >= oemc_pkg::SK_SURROUNDED && kind <= oemc_pkg::SK_LATERAL_OPENING)
                   || kind == oemc_pkg::SK_RIGHT_VIABLE || kind == oemc_pkg::SK_LEFT_VIABLE;
   assign lead_rule = req.front_blocked || kind == oemc_pkg::SK_LEAD_BLOCKED
                   || kind == oemc_pkg::SK_NOT_SURROUNDED
                   || kind == oemc_pkg::SK_RIGHT_INVALID;

   always_comb begin
      nst = state;
      n   = '0;
      res = '0;
      unique case (req.opcode)
         oemc_pkg::OP_SESSION: begin
            nst.backward = back_next;
            nst.session  = req.session_on;
            n            = 2'd1;
            if (req.session_on) begin
               nst.mode = back_next ? oemc_pkg::MODE_BWD : oemc_pkg::MODE_FWD;
               res[0]   = oemc_pkg::make_cmd(back_next ? oemc_pkg::CMD_REVERSE
                                                       : oemc_pkg::CMD_FORWARD, 1'b0);
            end else begin
               nst.mode = oemc_pkg::MODE_STOPPED;
               res[0]   = oemc_pkg::make_cmd(oemc_pkg::CMD_STOP, 1'b0);
            end
         end
         oemc_pkg::OP_PROBE: begin
            if (!state.session) begin
               n      = 2'd1;
               res[0] = oemc_pkg::make_cmd(oemc_pkg::CMD_SUPPRESS, 1'b0);
            end else begin
               nst.mode = oemc_pkg::MODE_PROBING;
               if (req.probe_reason == oemc_pkg::REASON_RIGHT_TURN
                   || req.probe_reason == oemc_pkg::REASON_SURROUNDED) begin
                  n      = 2'd2;
                  res[0] = oemc_pkg::make_act(oemc_pkg::ACT_SUSPEND);
                  res[1] = oemc_pkg::make_cmd(oemc_pkg::CMD_PROBE_RIGHT, state.backward);
               end else begin
                  n      = 2'd1;
                  res[0] = oemc_pkg::make_cmd(oemc_pkg::CMD_PROBE_RIGHT, state.backward);
               end
            end
         end
         oemc_pkg::OP_DUST_REQ: begin
            if (state.session && state.mode != oemc_pkg::MODE_SURR_REV
                && state.mode != oemc_pkg::MODE_AVOID
                && state.mode != oemc_pkg::MODE_PROBING) begin
               nst.mode = oemc_pkg::MODE_DUST;
               n        = 2'd3;
               res[0]   = oemc_pkg::make_cmd(oemc_pkg::CMD_STOP, 1'b0);
               res[1]   = oemc_pkg::make_cmd(state.backward ? oemc_pkg::CMD_SPIN_CCW
                                                            : oemc_pkg::CMD_SPIN_CW, 1'b0);
               res[2]   = oemc_pkg::make_act(oemc_pkg::ACT_BOOST);
            end
         end
         oemc_pkg::OP_DUST_DONE: begin
            nst.backward = ~state.backward;
            n            = 2'd1;
            res[0]       = oemc_pkg::make_act(oemc_pkg::ACT_NORMAL);
         end
         oemc_pkg::OP_SNAPSHOT: begin
            if (!state.session) begin
               n      = 2'd1;
               res[0] = oemc_pkg::make_cmd(oemc_pkg::CMD_SUPPRESS, 1'b0);
            end else if (!req.snapshot_valid || kind <= oemc_pkg::SK_PARTIAL_STALE) begin
               nst.mode = oemc_pkg::MODE_STOPPED;
               if (kind == oemc_pkg::SK_PARTIAL_STALE) begin
                  n      = 2'd1;
                  res[0] = oemc_pkg::make_cmd(oemc_pkg::CMD_SAFE_HOLD, 1'b0);
               end else begin
                  n      = 2'd2;
                  res[0] = oemc_pkg::make_cmd(req.front_blocked ? oemc_pkg::CMD_STOP_FALLBACK
                                                                : oemc_pkg::CMD_STOP, 1'b0);
                  res[1] = oemc_pkg::make_act(oemc_pkg::ACT_SUSPEND);
               end
            end else if (kind >= oemc_pkg::SK_AMBIGUOUS && kind <= oemc_pkg::SK_VALID) begin
               n = '0;
            end else if (kind == oemc_pkg::SK_UNSTABLE) begin
               n      = 2'd1;
               res[0] = oemc_pkg::make_cmd(oemc_pkg::CMD_SUPPRESS, 1'b0);
            end else if ((req.front_blocked && kind >= oemc_pkg::SK_RIGHT_VIABLE
                          && kind <= oemc_pkg::SK_NO_LATERAL)
                         || (!surr_rule && lead_rule)) begin
               nst.mode = oemc_pkg::MODE_AVOID;
               n        = 2'd2;
               res[0]   = oemc_pkg::make_cmd(oemc_pkg::CMD_HEADING, 1'b0);
               res[1]   = oemc_pkg::make_cmd(lead_turn, 1'b0);
            end else if (surr_rule) begin
               if (kind == oemc_pkg::SK_SURROUNDED) begin
                  nst.mode = oemc_pkg::MODE_SURR_REV;
                  n        = 2'd3;
                  res[0]   = oemc_pkg::make_cmd(oemc_pkg::CMD_HEADING, 1'b0);
                  res[1]   = oemc_pkg::make_act(oemc_pkg::ACT_SUSPEND);
                  res[2]   = oemc_pkg::make_cmd(oemc_pkg::CMD_REV_ESCAPE, 1'b0);
               end else if (kind == oemc_pkg::SK_REVERSE_READ
                            || kind == oemc_pkg::SK_REVERSE_SAMPLE) begin
                  nst.mode = oemc_pkg::MODE_SURR_REV;
                  n        = 2'd1;
                  res[0]   = oemc_pkg::make_cmd(oemc_pkg::CMD_REV_ESCAPE, 1'b0);
               end else if (kind == oemc_pkg::SK_RIGHT_VIABLE || req.right_open) begin
                  nst.mode = oemc_pkg::MODE_TURNING;
                  n        = 2'd2;
                  res[0]   = oemc_pkg::make_cmd(oemc_pkg::CMD_HEADING, 1'b0);
                  res[1]   = oemc_pkg::make_cmd(oemc_pkg::CMD_TURN_RIGHT, 1'b0);
               end else if (kind == oemc_pkg::SK_LEFT_VIABLE || req.left_open) begin
                  nst.mode = oemc_pkg::MODE_TURNING;
                  n        = 2'd2;
                  res[0]   = oemc_pkg::make_cmd(oemc_pkg::CMD_HEADING, 1'b0);
                  res[1]   = oemc_pkg::make_cmd(oemc_pkg::CMD_TURN_LEFT, 1'b0);
               end else begin
                  n      = 2'd1;
                  res[0] = oemc_pkg::make_cmd(oemc_pkg::CMD_FALLBACK, 1'b0);
               end
            end else if (req.front_safe || kind == oemc_pkg::SK_LEAD_SAFE) begin
               nst.mode = state.backward ? oemc_pkg::MODE_BWD : oemc_pkg::MODE_FWD;
               n        = 2'd2;
               res[0]   = oemc_pkg::make_cmd(state.backward ? oemc_pkg::CMD_REVERSE
                                                            : oemc_pkg::CMD_FORWARD, 1'b0);
               res[1]   = oemc_pkg::make_act(oemc_pkg::ACT_RESUME);
            end else begin
               n      = 2'd1;
               res[0] = oemc_pkg::make_cmd(oemc_pkg::CMD_FALLBACK, 1'b0);
            end
         end
         default: begin
            n = '0;
         end
      endcase

      // Every result of the event reports the mode left behind; the final one is marked.
      for (int i = 0; i < oemc_pkg::MAX_RESULTS; i++) begin
         res[i].motion_mode = nst.mode;
         res[i].last_result = (n == oemc_pkg::COUNT_W'(i + 1));
      end
   end

   assign decision.count      = n;
   assign decision.results    = res;
   assign decision.next_state = nst;

endmodule

// File: rtl/core/obstacle_escape_motion_coordinator_unit.sv
// Obstacle escape motion coordinator.
// The req_stream channel carries one event per transaction (session change, probe
// request, dust request, dust done or obstacle snapshot). The rsp_stream channel
// carries the resulting motion commands and cleaning actions, one per transaction,
// in order; the final result of each event has last_result set. Some events give
// no result at all and only update, or keep, the internal state.
// Latency: the first result of an event is offered the cycle after the event is
// accepted. An event's results (none to three) fill the three-entry result
// buffer, and a new event can be accepted in every cycle in which the buffer is
// empty or is handing over its last pending result.
// Reset (synchronous, active high) marks the session inactive, the travel direction
// forward and the motion mode stopped, and empties the result buffer.
// When the receiver stalls, pending results wait in the buffer and req_stream.ready
// stays low until the buffer drains to its last entry and that entry is taken.
`include "obstacle_escape_motion_coordinator_unit_defines.svh"

module obstacle_escape_motion_coordinator_unit (
   input  logic                 clock,
   input  logic                 reset,
   oemc_stream_if.sink          req_stream,
   oemc_stream_if.source        rsp_stream
);

   // Session flag, travel direction and motion mode as left by the last event.
   oemc_pkg::coord_state_type state_ff;
   oemc_pkg::coord_state_type state_in;

   // Pending results of the current event; entry 0 is the one on offer.
   oemc_pkg::rsp_payload_type [oemc_pkg::MAX_RESULTS-1:0] slot_ff;
   oemc_pkg::rsp_payload_type [oemc_pkg::MAX_RESULTS-1:0] slot_in;
   logic [oemc_pkg::COUNT_W-1:0]                          count_ff;
   logic [oemc_pkg::COUNT_W-1:0]                          count_in;

   oemc_pkg::decision_type decision;
   logic                   accept;
   logic                   pop;

   // All per-event decisions are made combinationally straight from the
   // incoming transaction and the current state.
   oemc_decoder u_decoder (
      .req      (req_stream.payload),
      .state    (state_ff),
      .decision (decision)
   );

   assign pop    = rsp_stream.valid && rsp_stream.ready;
   // A new event may enter when nothing is pending or the last pending result
   // is leaving in this very cycle.
   assign req_stream.ready = (count_ff == '0) || (count_ff == oemc_pkg::COUNT_W'(1) && pop);
   assign accept = req_stream.valid && req_stream.ready;

   assign rsp_stream.valid   = (count_ff != '0);
   assign rsp_stream.payload = slot_ff[0];

   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      count_in = count_ff;
      if (accept) begin
         state_in = decision.next_state;
         slot_in  = decision.results;
         count_in = decision.count;
      end else if (pop) begin
         // Shift the queue forward by one entry.
         for (int i = 0; i < oemc_pkg::MAX_RESULTS - 1; i++) begin
            slot_in[i] = slot_ff[i+1];
         end
         count_in = count_ff - oemc_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{session: 1'b0, backward: 1'b0, mode: oemc_pkg::MODE_STOPPED};
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Result payload needs no reset; it is only looked at while count_ff is non-zero.
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   `OEMC_ASSERT_IMP(a_accept_only_when_draining, clock, reset, accept, (count_ff == '0) || (count_ff == oemc_pkg::COUNT_W'(1) && pop), "event accepted while results of the previous event were still pending")

   `OEMC_ASSERT_IMP(a_last_only_at_tail, clock, reset, count_ff > oemc_pkg::COUNT_W'(1), !slot_ff[0].last_result, "final-result mark on an entry that is not the last pending one")

   `OEMC_ASSERT_IMP(a_tail_is_marked, clock, reset, count_ff == oemc_pkg::COUNT_W'(1), slot_ff[0].last_result, "last pending result is not marked as final")

   `OEMC_ASSERT_IMP(a_mode_matches_state, clock, reset, rsp_stream.valid, rsp_stream.payload.motion_mode == state_ff.mode, "reported motion mode differs from the stored mode")

   `OEMC_ASSERT_NEXT(a_empty_after_drain, clock, reset, pop && count_ff == oemc_pkg::COUNT_W'(1) && !accept, !rsp_stream.valid, "result offered after the buffer drained with no new event")

endmodule

// File: dv/obstacle_escape_motion_coordinator_unit_tb.sv
`timescale 1ns / 100ps

// Testbench for the obstacle escape motion coordinator.
// Events go in on req_stream, one per transaction, and the motion commands and
// cleaning actions come back on rsp_stream. Every accepted event is run through a
// behavioral copy of the coordinator kept in this file. That copy has its own
// session, direction and motion mode. The results it gives are queued and each
// result transaction is compared field by field with the oldest queued entry.
module obstacle_escape_motion_coordinator_unit_tb;
   import oemc_pkg::*;

   localparam int unsigned CLOCK_PERIOD     = 4;
   localparam int unsigned RESET_CYCLES     = 9;
   localparam int unsigned RANDOM_PER_PHASE = 52;
   localparam int unsigned DRAIN_LIMIT      = 20000;
   localparam int unsigned SETTLE_CYCLES    = 8;
   localparam int unsigned REPORT_LIMIT     = 10;
   localparam int unsigned TIMEOUT_NS       = 2000000;

   // Codes the package does not name. Opcodes five to seven and probe reason
   // three are outside the defined set, and kind 31 is the highest kind.
   localparam logic [2:0] OP_UNUSED_LOW  = 3'd5;
   localparam logic [2:0] OP_UNUSED_HIGH = 3'd7;
   localparam logic [1:0] REASON_OTHER   = 2'd2;
   localparam logic [1:0] REASON_UNUSED  = 2'd3;
   localparam logic [4:0] SK_BEYOND      = 5'd31;

   // Snapshot flag masks, in the order {blocked, safe, boxed, right, left}.
   localparam logic [4:0] F_NONE    = 5'b00000;
   localparam logic [4:0] F_BLOCKED = 5'b10000;
   localparam logic [4:0] F_SAFE    = 5'b01000;
   localparam logic [4:0] F_BOXED   = 5'b00100;
   localparam logic [4:0] F_RIGHT   = 5'b00010;
   localparam logic [4:0] F_LEFT    = 5'b00001;
   localparam logic [4:0] F_ALL     = 5'b11111;

   // One row of stimulus. A typed row carries its results written out by hand;
   // any other row is checked against the behavioral copy alone.
   typedef struct {
      req_payload_type ev;
      bit              typed;
      int unsigned     count;
      rsp_payload_type typed_results [2];
   } stimulus_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   oemc_stream_if #(.payload_type(req_payload_type)) req_if ();
   oemc_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   obstacle_escape_motion_coordinator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_if),
      .rsp_stream (rsp_if)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // State of the behavioral copy. It starts out as the block does after reset:
   // no session, forward travel, stopped.
   logic       model_session  = 1'b0;
   logic       model_backward = 1'b0;
   logic [2:0] model_mode     = MODE_STOPPED;

   rsp_payload_type  event_results [$];
   rsp_payload_type  due_results [$];
   stimulus_row_type directed_rows [$];
   stimulus_row_type offered_row;

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned fault_count = 0;

   function automatic void push_command(input logic [3:0] code, input logic side);
      rsp_payload_type r;
      r                = '0;
      r.result_kind    = KIND_COMMAND;
      r.motion_command = code;
      r.probe_side     = side;
      event_results.push_back(r);
   endfunction

   function automatic void push_action(input logic [1:0] code);
      rsp_payload_type r;
      r                 = '0;
      r.result_kind     = KIND_ACTION;
      r.cleaning_action = code;
      event_results.push_back(r);
   endfunction

   // Cruise in the current travel direction.
   function automatic void start_cruise();
      if (model_backward) begin
         model_mode = MODE_BWD;
         push_command(CMD_REVERSE, 1'b0);
      end else begin
         model_mode = MODE_FWD;
         push_command(CMD_FORWARD, 1'b0);
      end
   endfunction

   // Leading sector blocked: restore the heading, then turn away. A snapshot that
   // says the right turn is invalid prefers the left side when it is open.
   function automatic void steer_around(input logic [4:0] kind, input logic right_ok,
                                        input logic left_ok);
      model_mode = MODE_AVOID;
      push_command(CMD_HEADING, 1'b0);
      if (kind == SK_RIGHT_INVALID && left_ok) begin
         push_command(CMD_TURN_LEFT, 1'b0);
      end else if (right_ok) begin
         push_command(CMD_TURN_RIGHT, 1'b0);
      end else if (left_ok) begin
         push_command(CMD_TURN_LEFT, 1'b0);
      end else begin
         push_command(CMD_FALLBACK, 1'b0);
      end
   endfunction

   // Works out the results of one event into event_results and moves the state
   // on. Every result of the event carries the mode left at its end, and only the
   // final one is marked as last.
   function automatic void coordinate_event(input req_payload_type ev);
      logic [4:0] kind;
      kind = ev.snapshot_kind;
      event_results.delete();
      case (ev.opcode)
         OP_SESSION: begin
            if (ev.set_direction) model_backward = ev.direction_backward;
            model_session = ev.session_on;
            if (model_session) begin
               start_cruise();
            end else begin
               model_mode = MODE_STOPPED;
               push_command(CMD_STOP, 1'b0);
            end
         end
         OP_PROBE: begin
            if (!model_session) begin
               push_command(CMD_SUPPRESS, 1'b0);
            end else begin
               // Reason three falls in with the "other" reasons: no suspend.
               model_mode = MODE_PROBING;
               if (ev.probe_reason == REASON_RIGHT_TURN ||
                   ev.probe_reason == REASON_SURROUNDED) push_action(ACT_SUSPEND);
               push_command(CMD_PROBE_RIGHT, model_backward);
            end
         end
         OP_DUST_REQ: begin
            // Refused silently outside a session and while escaping or probing.
            if (model_session && model_mode != MODE_SURR_REV &&
                model_mode != MODE_AVOID && model_mode != MODE_PROBING) begin
               model_mode = MODE_DUST;
               push_command(CMD_STOP, 1'b0);
               push_command(model_backward ? CMD_SPIN_CCW : CMD_SPIN_CW, 1'b0);
               push_action(ACT_BOOST);
            end
         end
         OP_DUST_DONE: begin
            // Acts even with no session, and flips the travel direction.
            push_action(ACT_NORMAL);
            model_backward = ~model_backward;
         end
         OP_SNAPSHOT: begin
            // The rules are tried strictly in priority order.
            if (!model_session) begin
               push_command(CMD_SUPPRESS, 1'b0);
            end else if (!ev.snapshot_valid || kind <= SK_PARTIAL_STALE) begin
               model_mode = MODE_STOPPED;
               if (kind == SK_PARTIAL_STALE) begin
                  push_command(CMD_SAFE_HOLD, 1'b0);
               end else begin
                  push_command(ev.front_blocked ? CMD_STOP_FALLBACK : CMD_STOP, 1'b0);
                  push_action(ACT_SUSPEND);
               end
            end else if (kind >= SK_AMBIGUOUS && kind <= SK_VALID) begin
               // Ambiguous, incoherent and plain valid snapshots are ignored.
            end else if (kind == SK_UNSTABLE) begin
               push_command(CMD_SUPPRESS, 1'b0);
            end else if (ev.front_blocked && kind >= SK_RIGHT_VIABLE &&
                         kind <= SK_NO_LATERAL) begin
               steer_around(kind, ev.right_open, ev.left_open);
            end else if (ev.boxed_in ||
                         (kind >= SK_SURROUNDED && kind <= SK_LATERAL_OPENING) ||
                         kind == SK_RIGHT_VIABLE || kind == SK_LEFT_VIABLE) begin
               if (kind == SK_SURROUNDED) begin
                  model_mode = MODE_SURR_REV;
                  push_command(CMD_HEADING, 1'b0);
                  push_action(ACT_SUSPEND);
                  push_command(CMD_REV_ESCAPE, 1'b0);
               end else if (kind == SK_REVERSE_READ || kind == SK_REVERSE_SAMPLE) begin
                  model_mode = MODE_SURR_REV;
                  push_command(CMD_REV_ESCAPE, 1'b0);
               end else if (kind == SK_RIGHT_VIABLE || ev.right_open) begin
                  model_mode = MODE_TURNING;
                  push_command(CMD_HEADING, 1'b0);
                  push_command(CMD_TURN_RIGHT, 1'b0);
               end else if (kind == SK_LEFT_VIABLE || ev.left_open) begin
                  model_mode = MODE_TURNING;
                  push_command(CMD_HEADING, 1'b0);
                  push_command(CMD_TURN_LEFT, 1'b0);
               end else begin
                  push_command(CMD_FALLBACK, 1'b0);
               end
            end else if (ev.front_blocked || kind == SK_LEAD_BLOCKED ||
                         kind == SK_NOT_SURROUNDED || kind == SK_RIGHT_INVALID) begin
               steer_around(kind, ev.right_open, ev.left_open);
            end else if (ev.front_safe || kind == SK_LEAD_SAFE) begin
               start_cruise();
               push_action(ACT_RESUME);
            end else begin
               push_command(CMD_FALLBACK, 1'b0);
            end
         end
         default: begin
            // Undefined opcodes leave everything as it is.
         end
      endcase
      foreach (event_results[i]) begin
         event_results[i].motion_mode = model_mode;
         event_results[i].last_result = (i == event_results.size() - 1);
      end
   endfunction

   function automatic req_payload_type plain_event(input logic [2:0] op);
      req_payload_type ev;
      ev        = '0;
      ev.opcode = op;
      return ev;
   endfunction

   function automatic req_payload_type session_event(input logic on, input logic set_dir,
                                                     input logic backward);
      req_payload_type ev;
      ev                    = plain_event(OP_SESSION);
      ev.session_on         = on;
      ev.set_direction      = set_dir;
      ev.direction_backward = backward;
      return ev;
   endfunction

   function automatic req_payload_type probe_event(input logic [1:0] reason);
      req_payload_type ev;
      ev              = plain_event(OP_PROBE);
      ev.probe_reason = reason;
      return ev;
   endfunction

   function automatic req_payload_type snapshot_event(input logic valid,
                                                      input logic [4:0] kind,
                                                      input logic [4:0] flags);
      req_payload_type ev;
      ev                = plain_event(OP_SNAPSHOT);
      ev.snapshot_valid = valid;
      ev.snapshot_kind  = kind;
      {ev.front_blocked, ev.front_safe, ev.boxed_in, ev.right_open, ev.left_open} = flags;
      return ev;
   endfunction

   function automatic rsp_payload_type command_result(input logic [3:0] code,
                                                      input logic side,
                                                      input logic [2:0] mode,
                                                      input logic last);
      rsp_payload_type r;
      r                = '0;
      r.result_kind    = KIND_COMMAND;
      r.motion_command = code;
      r.probe_side     = side;
      r.motion_mode    = mode;
      r.last_result    = last;
      return r;
   endfunction

   function automatic rsp_payload_type action_result(input logic [1:0] code,
                                                     input logic [2:0] mode,
                                                     input logic last);
      rsp_payload_type r;
      r                 = '0;
      r.result_kind     = KIND_ACTION;
      r.cleaning_action = code;
      r.motion_mode     = mode;
      r.last_result     = last;
      return r;
   endfunction

   function automatic stimulus_row_type checked_row(input req_payload_type ev);
      stimulus_row_type row;
      row.ev               = ev;
      row.typed            = 1'b0;
      row.count            = 0;
      row.typed_results[0] = '0;
      row.typed_results[1] = '0;
      return row;
   endfunction

   function automatic stimulus_row_type typed_row(input req_payload_type ev,
                                                  input int unsigned count,
                                                  input rsp_payload_type r0,
                                                  input rsp_payload_type r1);
      stimulus_row_type row;
      row.ev               = ev;
      row.typed            = 1'b1;
      row.count            = count;
      row.typed_results[0] = r0;
      row.typed_results[1] = r1;
      return row;
   endfunction

   // Random events. All fields start out random, so every bit is exercised. The
   // mix keeps a session open most of the time, favors the snapshot kinds that
   // reach the escape rules, and leaves a small share of undefined opcodes.
   function automatic req_payload_type random_event();
      req_payload_type ev;
      int unsigned     raw;
      int unsigned     pick;
      raw  = $urandom;
      ev   = raw[$bits(req_payload_type)-1:0];
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         ev.opcode     = OP_SESSION;
         ev.session_on = ($urandom_range(0, 9) < 8);
      end else if (pick < 18) begin
         ev.opcode = OP_PROBE;
      end else if (pick < 28) begin
         ev.opcode = OP_DUST_REQ;
      end else if (pick < 35) begin
         ev.opcode = OP_DUST_DONE;
      end else if (pick < 96) begin
         ev.opcode         = OP_SNAPSHOT;
         ev.snapshot_valid = ($urandom_range(0, 9) != 0);
         if ($urandom_range(0, 9) < 7)
            ev.snapshot_kind = 5'($urandom_range(SK_UNSTABLE, SK_LEAD_SAFE));
      end else begin
         ev.opcode = 3'($urandom_range(OP_UNUSED_LOW, OP_UNUSED_HIGH));
      end
      return ev;
   endfunction

   function automatic string describe(input rsp_payload_type r);
      return $sformatf("kind=%0d cmd=%0d side=%0d act=%0d mode=%0d last=%0d",
                       r.result_kind, r.motion_command, r.probe_side,
                       r.cleaning_action, r.motion_mode, r.last_result);
   endfunction

   function automatic void note_fault(input string what, input string want_text,
                                      input rsp_payload_type got);
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
         $display("%0t: %s: expected %s, got %s", $time, what, want_text, describe(got));
   endfunction

   // Offers one event. The sender may idle first, at its current idle rate; valid then
   // stays high until the transaction is taken. Inputs change on falling edges
   // only, so every value is settled well before the rising edge samples it.
   task automatic send_row(input stimulus_row_type row);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= row.ev;
      offered_row     = row;
      do @(posedge clock);
      while (!(req_if.valid === 1'b1 && req_if.ready === 1'b1));
   endtask

   // Holds the request channel idle until the block has handed over every result
   // that is still owed.
   task automatic hold_requests();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
   endtask

   // Sends random events until the target number of defined events has gone in.
   // Undefined opcodes are sent too, but they do not count.
   task automatic random_events(input int unsigned target);
      req_payload_type ev;
      int unsigned     counted;
      counted = 0;
      while (counted < target) begin
         ev = random_event();
         send_row(checked_row(ev));
         if (ev.opcode <= OP_SNAPSHOT) counted++;
      end
   endtask

   // The receiver drops ready at random, at the rate of the current phase.
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Checking and prediction share one process on the rising edge. The result
   // of this edge is checked first, and then any event accepted at this edge is
   // predicted. Its results can only appear at a later edge.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (due_results.size() == 0) begin
               note_fault("result with nothing outstanding", "none", rsp_if.payload);
            end else begin
               want = due_results.pop_front();
               if (rsp_if.payload.result_kind !== want.result_kind ||
                   rsp_if.payload.motion_command !== want.motion_command ||
                   rsp_if.payload.probe_side !== want.probe_side ||
                   rsp_if.payload.cleaning_action !== want.cleaning_action ||
                   rsp_if.payload.motion_mode !== want.motion_mode ||
                   rsp_if.payload.last_result !== want.last_result)
                  note_fault("result mismatch", describe(want), rsp_if.payload);
            end
         end
         if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
            // The behavioral copy always runs so that its state keeps up. On a
            // typed row the hand-written results are what gets checked.
            coordinate_event(req_if.payload);
            if (offered_row.typed) begin
               for (int i = 0; i < offered_row.count; i++)
                  due_results.push_back(offered_row.typed_results[i]);
            end else begin
               foreach (event_results[i]) due_results.push_back(event_results[i]);
            end
         end
      end
   end

   initial begin
      req_payload_type loud;
      int unsigned     waited;

      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      send_idle_pct  = 27;
      recv_idle_pct  = 87;

      // Directed table. It starts with no session, so snapshots and probes are
      // suppressed and a dust request is refused. The undefined opcodes carry
      // every other bit set and must do nothing. Dust done acts even with no
      // session, and it turns the travel direction to backward.
      directed_rows.push_back(typed_row(snapshot_event(1'b1, SK_LEAD_SAFE, F_SAFE), 1,
         command_result(CMD_SUPPRESS, 1'b0, MODE_STOPPED, 1'b1), '0));
      directed_rows.push_back(typed_row(probe_event(REASON_RIGHT_TURN), 1,
         command_result(CMD_SUPPRESS, 1'b0, MODE_STOPPED, 1'b1), '0));
      directed_rows.push_back(typed_row(plain_event(OP_DUST_REQ), 0, '0, '0));
      loud        = '1;
      loud.opcode = OP_UNUSED_LOW;
      directed_rows.push_back(typed_row(loud, 0, '0, '0));
      loud.opcode = OP_UNUSED_HIGH;
      directed_rows.push_back(typed_row(loud, 0, '0, '0));
      directed_rows.push_back(typed_row(plain_event(OP_DUST_DONE), 1,
         action_result(ACT_NORMAL, MODE_STOPPED, 1'b1), '0));

      // A session that keeps the direction, then one that sets it to forward.
      directed_rows.push_back(checked_row(session_event(1'b1, 1'b0, 1'b0)));
      directed_rows.push_back(typed_row(session_event(1'b1, 1'b1, 1'b0), 1,
         command_result(CMD_FORWARD, 1'b0, MODE_FWD, 1'b1), '0));

      // An invalid snapshot with the leading sector blocked stops the robot and
      // suspends cleaning. A partly stale one holds. An ambiguous one is ignored.
      directed_rows.push_back(typed_row(snapshot_event(1'b0, SK_VALID, F_BLOCKED), 2,
         command_result(CMD_STOP_FALLBACK, 1'b0, MODE_STOPPED, 1'b0),
         action_result(ACT_SUSPEND, MODE_STOPPED, 1'b1)));
      directed_rows.push_back(typed_row(snapshot_event(1'b1, SK_PARTIAL_STALE, F_NONE), 1,
         command_result(CMD_SAFE_HOLD, 1'b0, MODE_STOPPED, 1'b1), '0));
      directed_rows.push_back(typed_row(snapshot_event(1'b1, SK_AMBIGUOUS, F_ALL), 0,
         '0, '0));
      directed_rows.push_back(checked_row(snapshot_event(1'b1, SK_UNSTABLE,
                                                         F_BLOCKED | F_BOXED)));

      // The dust manoeuvre in both directions, then refused while probing. The
      // probe reason three falls in with the "other" reasons.
      directed_rows.push_back(checked_row(plain_event(OP_DUST_REQ)));
      directed_rows.push_back(checked_row(plain_event(OP_DUST_DONE)));
      directed_rows.push_back(checked_row(plain_event(OP_DUST_REQ)));
      directed_rows.push_back(checked_row(probe_event(REASON_SURROUNDED)));
      directed_rows.push_back(checked_row(plain_event(OP_DUST_REQ)));
      directed_rows.push_back(checked_row(probe_event(REASON_UNUSED)));

      // The escape rules: a right turn reported invalid prefers the left side,
      // full surround reverses out, a dust request during that is refused, and a
      // kind beyond the list leaves only the flags to decide. The two after that take
      // the blocked fallback and the safe cruise, and then the session is switched off.
      directed_rows.push_back(checked_row(snapshot_event(1'b1, SK_RIGHT_INVALID,
                                                         F_BLOCKED | F_RIGHT | F_LEFT)));
      directed_rows.push_back(checked_row(snapshot_event(1'b1, SK_SURROUNDED, F_NONE)));
      directed_rows.push_back(checked_row(plain_event(OP_DUST_REQ)));
      directed_rows.push_back(checked_row(snapshot_event(1'b1, SK_BEYOND,
                                                         F_BOXED | F_RIGHT)));
      directed_rows.push_back(checked_row(snapshot_event(1'b1, SK_NOT_SURROUNDED, F_NONE)));
      directed_rows.push_back(checked_row(snapshot_event(1'b1, SK_LEAD_SAFE, F_NONE)));
      directed_rows.push_back(typed_row(session_event(1'b0, 1'b1, 1'b0), 1,
         command_result(CMD_STOP, 1'b0, MODE_STOPPED, 1'b1), '0));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // First phase: the sender is mostly busy and the receiver mostly stalls.
      foreach (directed_rows[i]) send_row(directed_rows[i]);
      random_events(RANDOM_PER_PHASE);

      // Second phase: the sender waits for every owed result first, and then the
      // two sides swap their idle rates.
      hold_requests();
      send_idle_pct = 87;
      recv_idle_pct = 27;
      random_events(RANDOM_PER_PHASE);

      // Third phase: neither side idles, so events are offered back to back.
      hold_requests();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_events(RANDOM_PER_PHASE);

      @(negedge clock);
      req_if.valid <= 1'b0;
      waited = 0;
      while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      // Wait out SETTLE_CYCLES more, so that any stray result still shows up.
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (due_results.size() != 0)
         $display("%0d expected results never arrived", due_results.size());
      if (fault_count == 0 && due_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // A hung handshake must not keep the run going forever.
   initial begin
      #(TIMEOUT_NS);
      $display("FAILURE");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/oemc_pkg.sv
rtl/core/oemc_stream_if.sv
rtl/core/oemc_decoder.sv
rtl/core/obstacle_escape_motion_coordinator_unit.sv
dv/obstacle_escape_motion_coordinator_unit_tb.sv
